// ===== hw/rtl/nearest_palette_color_match_assert.svh =====
// Assertion macros for the nearest palette color match RTL.
`ifndef NEAREST_PALETTE_COLOR_MATCH_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MATCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NPCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("npcm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define NPCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("npcm assertion failed");

`endif

// ===== hw/rtl/npcm_pkg.sv =====
// Package: types, constants and helpers for the nearest palette color match.
package npcm_pkg;

  localparam int COLOR_W             = 8;
  localparam int RGB_W               = 3 * COLOR_W;
  localparam int IDX_IN_W            = 8;
  localparam int IDX_OUT_W           = 8;
  localparam int DIST_W              = 20;
  localparam int SQ_W                = 2 * COLOR_W;
  localparam int WGT_W               = 10;
  localparam int PROD_W              = WGT_W + SQ_W;
  localparam int FRAC_SH             = 8;
  localparam int TERM_W              = PROD_W - FRAC_SH;
  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int RED_BASE            = 512;
  localparam int BLUE_BASE           = 767;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_t;

  // Control tag riding along with each scanned entry.
  typedef struct packed {
    logic scan;
    logic last;
  } tag_t;

  // Distance result handed back to the sequencer.
  typedef struct packed {
    logic              scan;
    logic              last;
    logic              hit;
    logic [DIST_W-1:0] distance;
  } res_t;

  // Entries at or above 2**IDX_IN_W can never be written.
  function automatic int store_depth(input int entries);
    store_depth = (entries < (2 ** IDX_IN_W)) ? entries : (2 ** IDX_IN_W);
  endfunction

endpackage

// ===== hw/rtl/npcm_if.sv =====
// Valid/ready channel interfaces for query/write transactions and results.
interface npcm_in_if;
  import npcm_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [IDX_IN_W-1:0] entry_index;
  logic                entry_valid;
  logic [COLOR_W-1:0]  red;
  logic [COLOR_W-1:0]  green;
  logic [COLOR_W-1:0]  blue;

  modport source (output valid, action, entry_index, entry_valid, red, green, blue,
                  input ready);
  modport sink   (input valid, action, entry_index, entry_valid, red, green, blue,
                  output ready);
endinterface

interface npcm_out_if;
  import npcm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] best_index;
  logic [DIST_W-1:0]    best_distance;
  logic                 match_found;

  modport source (output valid, best_index, best_distance, match_found, input ready);
  modport sink   (input valid, best_index, best_distance, match_found, output ready);
endinterface

// ===== hw/rtl/npcm_palette.sv =====
// Palette store: color memory with registered read and per-entry valid flops.
module npcm_palette #(
  parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF,
  parameter int DEPTH           = npcm_pkg::store_depth(PALETTE_ENTRIES),
  parameter int ADDR_W          = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [npcm_pkg::RGB_W-1:0] wr_color,
  input  logic                      wr_valid,
  input  logic                      rd_en,
  input  logic [ADDR_W-1:0]         rd_addr,
  output logic [npcm_pkg::RGB_W-1:0] rd_color_r,
  output logic                      rd_valid_r
);
  import npcm_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_color_r <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= wr_valid;
    end
  end

endmodule

// ===== hw/rtl/npcm_dist.sv =====
// Pipelined redmean distance unit, one palette entry per cycle.
module npcm_dist #(
  parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF,
  parameter int ADDR_W          = $clog2(npcm_pkg::store_depth(PALETTE_ENTRIES))
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [npcm_pkg::COLOR_W-1:0] q_red,
  input  logic [npcm_pkg::COLOR_W-1:0] q_green,
  input  logic [npcm_pkg::COLOR_W-1:0] q_blue,
  input  logic [npcm_pkg::RGB_W-1:0]   e_color,
  input  logic                         e_hit,
  input  npcm_pkg::tag_t               in_tag,
  input  logic [ADDR_W-1:0]            in_idx,
  output npcm_pkg::res_t               res,
  output logic [ADDR_W-1:0]            res_idx
);
  import npcm_pkg::*;

  logic [COLOR_W-1:0] er, eg, eb;
  logic [COLOR_W-1:0] dr, dg, db, mean;
  logic [COLOR_W:0]   rsum;

  // stage A: differences, squares, weights
  tag_t               a_tag_r;
  logic               a_hit_r;
  logic [ADDR_W-1:0]  a_idx_r;
  logic [SQ_W-1:0]    a_dr2_r, a_dg2_r, a_db2_r;
  logic [WGT_W-1:0]   a_wr_r, a_wb_r;

  // stage B: weighted terms
  tag_t               b_tag_r;
  logic               b_hit_r;
  logic [ADDR_W-1:0]  b_idx_r;
  logic [PROD_W-1:0]  b_pr_r, b_pb_r;
  logic [SQ_W-1:0]    b_dg2_r;
  logic [TERM_W-1:0]  tr, tg, tb;

  // stage C: sum
  tag_t               c_tag_r;
  logic               c_hit_r;
  logic [ADDR_W-1:0]  c_idx_r;
  logic [DIST_W-1:0]  c_dist_r;

  assign er   = e_color[RGB_W-1 -: COLOR_W];
  assign eg   = e_color[2*COLOR_W-1 -: COLOR_W];
  assign eb   = e_color[COLOR_W-1:0];
  assign dr   = (er > q_red)   ? (er - q_red)   : (q_red - er);
  assign dg   = (eg > q_green) ? (eg - q_green) : (q_green - eg);
  assign db   = (eb > q_blue)  ? (eb - q_blue)  : (q_blue - eb);
  assign rsum = {1'b0, er} + {1'b0, q_red};
  assign mean = rsum[COLOR_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
      b_tag_r <= '0;
      c_tag_r <= '0;
    end else begin
      a_tag_r <= in_tag;
      b_tag_r <= a_tag_r;
      c_tag_r <= b_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    a_hit_r <= e_hit;
    a_idx_r <= in_idx;
    a_dr2_r <= SQ_W'(dr) * SQ_W'(dr);
    a_dg2_r <= SQ_W'(dg) * SQ_W'(dg);
    a_db2_r <= SQ_W'(db) * SQ_W'(db);
    a_wr_r  <= WGT_W'(RED_BASE) + WGT_W'(mean);
    a_wb_r  <= WGT_W'(BLUE_BASE) - WGT_W'(mean);
  end

  always_ff @(posedge clk) begin
    b_hit_r <= a_hit_r;
    b_idx_r <= a_idx_r;
    b_pr_r  <= PROD_W'(a_wr_r) * PROD_W'(a_dr2_r);
    b_pb_r  <= PROD_W'(a_wb_r) * PROD_W'(a_db2_r);
    b_dg2_r <= a_dg2_r;
  end

  assign tr = b_pr_r[PROD_W-1:FRAC_SH];
  assign tb = b_pb_r[PROD_W-1:FRAC_SH];
  assign tg = {b_dg2_r, 2'b00};

  always_ff @(posedge clk) begin
    c_hit_r  <= b_hit_r;
    c_idx_r  <= b_idx_r;
    c_dist_r <= DIST_W'(tr) + DIST_W'(tg) + DIST_W'(tb);
  end

  assign res.scan     = c_tag_r.scan;
  assign res.last     = c_tag_r.last;
  assign res.hit      = c_hit_r;
  assign res.distance = c_dist_r;
  assign res_idx      = c_idx_r;

endmodule

// ===== hw/rtl/npcm_seq.sv =====
// Sequencer: accepts transactions, walks the palette, tracks the best match.
module npcm_seq #(
  parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF,
  parameter int DEPTH           = npcm_pkg::store_depth(PALETTE_ENTRIES),
  parameter int ADDR_W          = $clog2(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  npcm_in_if.sink                      in_ch,
  npcm_out_if.source                   out_ch,
  output logic                         wr_en,
  output logic [ADDR_W-1:0]            wr_addr,
  output logic [npcm_pkg::RGB_W-1:0]   wr_color,
  output logic                         wr_valid,
  output logic                         rd_en,
  output logic [ADDR_W-1:0]            rd_addr,
  output npcm_pkg::tag_t               iss_tag_r,
  output logic [ADDR_W-1:0]            iss_idx_r,
  output logic [npcm_pkg::COLOR_W-1:0] q_red_r,
  output logic [npcm_pkg::COLOR_W-1:0] q_green_r,
  output logic [npcm_pkg::COLOR_W-1:0] q_blue_r,
  input  npcm_pkg::res_t               res,
  input  logic [ADDR_W-1:0]            res_idx
);
  import npcm_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r;
  logic                accept, in_range, out_load, scan_last, better;
  logic                found_r;
  logic [ADDR_W-1:0]   best_i_r;
  logic [DIST_W-1:0]   best_d_r;
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [DIST_W-1:0]   out_dist_r;
  logic                out_found_r;

  assign accept    = in_ch.valid && in_ch.ready;
  assign in_range  = 32'(in_ch.entry_index) < 32'(PALETTE_ENTRIES);
  assign scan_last = (cnt_r == LAST_ADDR);
  assign better    = res.scan && res.hit && (!found_r || (res.distance < best_d_r));

  assign wr_en    = accept && (in_ch.action == ACT_WRITE) && in_range;
  assign wr_addr  = in_ch.entry_index[ADDR_W-1:0];
  assign wr_color = {in_ch.red, in_ch.green, in_ch.blue};
  assign wr_valid = in_ch.entry_valid;
  assign rd_addr  = cnt_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && (in_ch.action == ACT_QUERY)) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_last) state_nxt = ST_WAIT;
      ST_WAIT: if (res.scan && res.last) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_SCAN: rd_en       = 1'b1;
      ST_WAIT: ;
      ST_DONE: out_load    = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      iss_tag_r   <= '0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      iss_tag_r.scan <= rd_en;
      iss_tag_r.last <= rd_en && scan_last;
    end
  end

  always_ff @(posedge clk) begin
    iss_idx_r <= cnt_r;
    if (accept) begin
      q_red_r   <= in_ch.red;
      q_green_r <= in_ch.green;
      q_blue_r  <= in_ch.blue;
      cnt_r     <= '0;
      found_r   <= 1'b0;
      best_i_r  <= '0;
      best_d_r  <= '0;
    end else begin
      if (rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (better) begin
        found_r  <= 1'b1;
        best_i_r <= res_idx;
        best_d_r <= res.distance;
      end
    end
    if (out_load) begin
      out_idx_r   <= IDX_OUT_W'(best_i_r);
      out_dist_r  <= best_d_r;
      out_found_r <= found_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.best_index    = out_idx_r;
  assign out_ch.best_distance = out_dist_r;
  assign out_ch.match_found   = out_found_r;

endmodule

// ===== hw/rtl/nearest_palette_color_match.sv =====
// Top level: nearest palette color match under the redmean distance.
// A write transaction stores one palette entry (color and valid mark); indexes at
// or above PALETTE_ENTRIES are dropped, and since entry_index is 8 bits at most 256
// entries are stored. A query transaction walks every stored entry through one
// shared distance pipeline, one entry per cycle, and returns the lowest-index
// valid entry at minimum distance. The input is not ready during a query; a
// result waiting on the output does not block further transactions until the
// next query finishes. No clearing pass is needed after reset.
`include "nearest_palette_color_match_assert.svh"

module nearest_palette_color_match #(
  parameter int PALETTE_ENTRIES = npcm_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  npcm_in_if.sink     in_ch,
  npcm_out_if.source  out_ch
);
  import npcm_pkg::*;

  localparam int DEPTH  = store_depth(PALETTE_ENTRIES);
  localparam int ADDR_W = $clog2(DEPTH);

  logic              wr_en, wr_valid, rd_en, rd_valid_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr, iss_idx_r, res_idx;
  logic [RGB_W-1:0]  wr_color, rd_color_r;
  logic [COLOR_W-1:0] q_red_r, q_green_r, q_blue_r;
  tag_t              iss_tag_r;
  res_t              res;

  npcm_seq #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .DEPTH          (DEPTH),
    .ADDR_W         (ADDR_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_color  (wr_color),
    .wr_valid  (wr_valid),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .iss_tag_r (iss_tag_r),
    .iss_idx_r (iss_idx_r),
    .q_red_r   (q_red_r),
    .q_green_r (q_green_r),
    .q_blue_r  (q_blue_r),
    .res       (res),
    .res_idx   (res_idx)
  );

  npcm_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .DEPTH          (DEPTH),
    .ADDR_W         (ADDR_W)
  ) u_palette (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_color   (wr_color),
    .wr_valid   (wr_valid),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_color_r (rd_color_r),
    .rd_valid_r (rd_valid_r)
  );

  npcm_dist #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .ADDR_W         (ADDR_W)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_red   (q_red_r),
    .q_green (q_green_r),
    .q_blue  (q_blue_r),
    .e_color (rd_color_r),
    .e_hit   (rd_valid_r),
    .in_tag  (iss_tag_r),
    .in_idx  (iss_idx_r),
    .res     (res),
    .res_idx (res_idx)
  );

  `NPCM_ASSERT_IMP(a_scan_blocks_input, clk, rst_n, rd_en, !in_ch.ready)
  `NPCM_ASSERT_IMP(a_res_follows_issue, clk, rst_n, res.scan, $past(rd_en, 4))
  `NPCM_ASSERT_IMP(a_no_match_zero, clk, rst_n, out_ch.valid && !out_ch.match_found,
                   (out_ch.best_index == '0) && (out_ch.best_distance == '0))
  `NPCM_ASSERT_NXT(a_query_busy, clk, rst_n,
                   in_ch.valid && in_ch.ready && (in_ch.action == ACT_QUERY), !in_ch.ready)

endmodule

// ===== tb/tb_nearest_palette_color_match.sv =====
// Testbench for nearest_palette_color_match: random palette writes and queries checked against a redmean predictor.
module tb_nearest_palette_color_match;
  import npcm_pkg::*;

  localparam int NUM_RANDOM = 600;
  localparam int DEPTH      = PALETTE_ENTRIES_DEF;
  localparam int DRAIN      = 300;

  typedef struct {
    logic                action;
    logic [IDX_IN_W-1:0] entry_index;
    logic                entry_valid;
    logic [COLOR_W-1:0]  red;
    logic [COLOR_W-1:0]  green;
    logic [COLOR_W-1:0]  blue;
  } color_txn_t;

  typedef struct {
    logic [IDX_OUT_W-1:0] best_index;
    logic [DIST_W-1:0]    best_distance;
    logic                 match_found;
  } match_t;

  logic clk;
  logic rst_n;

  npcm_in_if  in_ch();
  npcm_out_if out_ch();

  nearest_palette_color_match dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  color_txn_t       pending_txns[$];
  match_t           match_q[$];
  logic [RGB_W-1:0] seen_colors[$];

  logic [RGB_W-1:0] palette_rgb[DEPTH];
  logic             palette_live[DEPTH];

  logic in_fire;
  int   in_gap;
  int   out_stall;
  int   accepted_cnt;
  int   fail_cnt;

  function automatic logic [DIST_W-1:0] redmean_dist(input logic [COLOR_W-1:0] r,
                                                     input logic [COLOR_W-1:0] g,
                                                     input logic [COLOR_W-1:0] b,
                                                     input logic [RGB_W-1:0] c);
    int unsigned cr, cg, cb, dr, dg, db, m, t_red, t_grn, t_blu;
    cr = c[23:16];
    cg = c[15:8];
    cb = c[7:0];
    dr = (cr > r) ? cr - r : r - cr;
    dg = (cg > g) ? cg - g : g - cg;
    db = (cb > b) ? cb - b : b - cb;
    m = (r + cr) >> 1;
    t_red = ((RED_BASE + m) * dr * dr) >> FRAC_SH;
    t_grn = 4 * dg * dg;
    t_blu = ((BLUE_BASE - m) * db * db) >> FRAC_SH;
    return DIST_W'(t_red + t_grn + t_blu);
  endfunction

  // Lowest index wins on equal distance.
  function automatic match_t nearest_entry(input logic [COLOR_W-1:0] r,
                                           input logic [COLOR_W-1:0] g,
                                           input logic [COLOR_W-1:0] b);
    match_t           res;
    logic [DIST_W-1:0] d;
    res.best_index    = '0;
    res.best_distance = '0;
    res.match_found   = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (palette_live[i]) begin
        d = redmean_dist(r, g, b, palette_rgb[i]);
        if (!res.match_found || d < res.best_distance) begin
          res.match_found   = 1'b1;
          res.best_distance = d;
          res.best_index    = IDX_OUT_W'(i);
        end
      end
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones, and calm stretches with none.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if ((accepted_cnt / 80) % 3 == 2) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  task automatic add_write(input logic [IDX_IN_W-1:0] idx, input logic v,
                           input logic [RGB_W-1:0] c);
    color_txn_t t;
    t.action      = ACT_WRITE;
    t.entry_index = idx;
    t.entry_valid = v;
    {t.red, t.green, t.blue} = c;
    pending_txns.push_back(t);
    seen_colors.push_back(c);
  endtask

  task automatic add_query(input logic [RGB_W-1:0] c);
    color_txn_t t;
    t.action      = ACT_QUERY;
    t.entry_index = IDX_IN_W'($urandom);
    t.entry_valid = 1'($urandom);
    {t.red, t.green, t.blue} = c;
    pending_txns.push_back(t);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Input side: update the palette model at each accepted write, predict at each accepted query.
  always @(posedge clk) begin
    match_t m;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) palette_live[i] = 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      accepted_cnt <= accepted_cnt + 1;
      if (in_ch.action == ACT_WRITE) begin
        if (in_ch.entry_index < DEPTH) begin
          palette_rgb[in_ch.entry_index]  = {in_ch.red, in_ch.green, in_ch.blue};
          palette_live[in_ch.entry_index] = in_ch.entry_valid;
        end
      end else begin
        m = nearest_entry(in_ch.red, in_ch.green, in_ch.blue);
        match_q.push_back(m);
      end
    end
  end

  // Driver
  always @(negedge clk) begin
    color_txn_t t;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (in_gap > 0) begin
        in_ch.valid <= 1'b0;
        in_gap      <= in_gap - 1;
      end else if (pending_txns.size() > 0) begin
        t = pending_txns.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.action      <= t.action;
        in_ch.entry_index <= t.entry_index;
        in_ch.entry_valid <= t.entry_valid;
        in_ch.red         <= t.red;
        in_ch.green       <= t.green;
        in_ch.blue        <= t.blue;
        in_gap            <= idle_cycles();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result backpressure
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_ch.ready <= 1'b0;
      out_stall    <= out_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
      out_stall    <= idle_cycles();
    end
  end

  // Monitor
  always @(posedge clk) begin
    match_t m;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (match_q.size() == 0) begin
        fail_cnt <= fail_cnt + 1;
        $display("%0t: unexpected result idx=%0d dist=%0d found=%0b", $time,
                 out_ch.best_index, out_ch.best_distance, out_ch.match_found);
      end else begin
        m = match_q.pop_front();
        if (out_ch.best_index !== m.best_index || out_ch.best_distance !== m.best_distance ||
            out_ch.match_found !== m.match_found) begin
          fail_cnt <= fail_cnt + 1;
          $display("%0t: expected idx=%0d dist=%0d found=%0b, got idx=%0d dist=%0d found=%0b",
                   $time, m.best_index, m.best_distance, m.match_found,
                   out_ch.best_index, out_ch.best_distance, out_ch.match_found);
        end
      end
    end
  end

  initial begin
    logic [RGB_W-1:0] c;
    int               sel;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_WRITE;
    in_ch.entry_index = '0;
    in_ch.entry_valid = 1'b0;
    in_ch.red         = '0;
    in_ch.green       = '0;
    in_ch.blue        = '0;
    out_ch.ready      = 1'b0;
    in_fire           = 1'b0;
    in_gap            = 0;
    out_stall         = 0;
    accepted_cnt      = 0;
    fail_cnt          = 0;
    rst_n             = 1'b0;

    // Directed: empty palette, black, extremes, invalid write, ties, empty again.
    add_query(24'h000000);
    add_write(8'd0, 1'b1, 24'h000000);
    add_query(24'h000000);
    add_write(8'd255, 1'b1, 24'hFFFFFF);
    add_query(24'hFFFFFF);
    add_query(24'h000000);
    add_write(8'd0, 1'b0, 24'h000000);
    add_query(24'h000000);
    add_write(8'd10, 1'b1, 24'h6496C8);
    add_write(8'd20, 1'b1, 24'h6496C8);
    add_write(8'd5, 1'b0, 24'h6496C8);
    add_query(24'h6496C8);
    add_query(24'hFF00FF);
    add_query(24'h00FF00);
    add_write(8'd10, 1'b0, 24'h6496C8);
    add_write(8'd20, 1'b0, 24'h6496C8);
    add_write(8'd255, 1'b0, 24'hFFFFFF);
    add_query(24'h010203);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        if ($urandom_range(0, 99) < 25)
          c = seen_colors[$urandom_range(0, seen_colors.size() - 1)];
        else
          c = RGB_W'($urandom);
        add_write(($urandom_range(0, 99) < 40) ? IDX_IN_W'($urandom_range(0, 7))
                                               : IDX_IN_W'($urandom_range(0, 255)),
                  ($urandom_range(0, 99) < 70), c);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
          c = RGB_W'($urandom);
        end else if (sel < 80) begin
          c = seen_colors[$urandom_range(0, seen_colors.size() - 1)];
          if ($urandom_range(0, 1)) c[8] = ~c[8];
        end else begin
          c = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
        end
        add_query(c);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_txns.size() != 0 || in_ch.valid) @(posedge clk);
    while (match_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== nearest_palette_color_match.f =====
+incdir+hw/rtl
hw/rtl/npcm_pkg.sv
hw/rtl/npcm_if.sv
hw/rtl/npcm_palette.sv
hw/rtl/npcm_dist.sv
hw/rtl/npcm_seq.sv
hw/rtl/nearest_palette_color_match.sv
tb/tb_nearest_palette_color_match.sv
